### sv/lac_pkg.sv
// Shared types and codes for the fully associative LRU cache.
package lac_pkg;

  // Operation codes carried in the func field of a request.
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // One request as presented on the input ports.
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  // One result as presented on the output ports.
  typedef struct packed {
    logic        hit;
    logic [31:0] value_res;
    logic        evicted_valid;
    logic [31:0] evicted_key;
  } rsp_t;

  // Update command broadcast to every cell of the recency chain.
  typedef struct packed {
    logic update;
    logic lookup;
    logic insert;
    logic remove;
    logic hit;
  } cmd_t;

endpackage

### sv/lac_cell.sv
// One slot of the recency chain: holds an entry and moves it to a neighbour on update.
module lac_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lac_pkg::cmd_t         cmd_i,
  input  logic                  cmp_en_i,
  input  logic [KEY_BITS-1:0]   cmp_key_i,
  input  logic                  found_i,
  output logic                  found_o,
  output logic                  first_o,
  input  logic [KEY_BITS-1:0]   prev_key_i,
  input  logic [VALUE_BITS-1:0] prev_val_i,
  input  logic                  prev_vld_i,
  input  logic [KEY_BITS-1:0]   next_key_i,
  input  logic [VALUE_BITS-1:0] next_val_i,
  input  logic                  next_vld_i,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] val_o,
  output logic                  vld_o
);
  import lac_pkg::*;

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic                  vld_q;
  logic                  match_q;
  logic                  take_prev;
  logic                  take_next;

  // A match further up the chain is more recent, so it wins.
  assign found_o = found_i | match_q;
  assign first_o = match_q & ~found_i;

  // Lookup and insert push entries one step towards the old end; a remove
  // pulls the entries behind the removed one forwards.
  assign take_prev = cmd_i.update &
                     (cmd_i.insert | (cmd_i.lookup & cmd_i.hit & ~found_i));
  assign take_next = cmd_i.update & cmd_i.remove & cmd_i.hit & found_o;

  // Compare result is captured when a request is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (cmp_en_i) begin
      match_q <= vld_q & (key_q == cmp_key_i);
    end
  end

  // Valid mark is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take_prev) begin
      vld_q <= prev_vld_i;
    end else if (take_next) begin
      vld_q <= next_vld_i;
    end
  end

  // Key and value are only seen through a valid entry.
  always_ff @(posedge clk_i) begin
    if (take_prev) begin
      key_q <= prev_key_i;
      val_q <= prev_val_i;
    end else if (take_next) begin
      key_q <= next_key_i;
      val_q <= next_val_i;
    end
  end

  assign key_o = key_q;
  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

### sv/lru_associative_cache_top.sv
// Top level of the fully associative LRU cache built as a chain of recency cells.
//
//   Channel   Ports                    Handshake
//   request   start, busy, req_i       taken when start is high and busy is low
//   result    rsp_valid_o, rsp_o       shown for one cycle, always taken
//
// Each request is handled in turn: the key is compared in every cell at the
// accepting edge, then the chain shifts and the result is registered in the
// update cycle that follows. busy is high for that one update cycle, so a new
// request can be taken as soon as it ends, also while the previous result is on the ports.
// The cells keep the recency order by position; after reset all are invalid.
// The receiver cannot stall, so nothing here waits on the result side.
module lru_associative_cache_top #(
  parameter int WAYS       = 8,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lac_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output lac_pkg::rsp_t rsp_o
);
  import lac_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic                  state_q, state_d;
  req_t                  req_q;
  rsp_t                  rsp_q, rsp_d;
  logic                  rsp_valid_q;
  logic                  accept;
  cmd_t                  cmd;
  logic [KEY_BITS-1:0]   cmp_key;
  logic [KEY_BITS-1:0]   new_key;
  logic [VALUE_BITS-1:0] new_val;

  logic [WAYS:0]         found;
  logic [WAYS-1:0]       first;
  logic [KEY_BITS-1:0]   cell_key [WAYS];
  logic [VALUE_BITS-1:0] cell_val [WAYS];
  logic                  cell_vld [WAYS];
  logic [KEY_BITS-1:0]   sel_key;
  logic [VALUE_BITS-1:0] sel_val;
  logic [KEY_BITS-1:0]   head_key, tail_key;
  logic [VALUE_BITS-1:0] head_val, tail_val;
  logic [63:0]           key_ext, sel_val_ext, ev_key_ext;

  assign accept = start & (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // Request fields sized to the stored widths.
  assign key_ext = 64'(req_i.key);
  assign cmp_key = key_ext[KEY_BITS-1:0];
  always_comb begin
    logic [63:0] qk, qv;
    qk      = 64'(req_q.key);
    qv      = 64'(req_q.value);
    new_key = qk[KEY_BITS-1:0];
    new_val = qv[VALUE_BITS-1:0];
  end

  // Sequencer: idle, then an update state for each accepted request.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_UPD;
      ST_UPD:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // Command broadcast to all cells during the update cycle.
  assign found[0]   = 1'b0;
  assign cmd.update = (state_q == ST_UPD);
  assign cmd.lookup = (req_q.func == FUNC_LOOKUP);
  assign cmd.insert = (req_q.func == FUNC_INSERT);
  assign cmd.remove = (req_q.func == FUNC_REMOVE);
  assign cmd.hit    = found[WAYS];

  // Pick out the most recent matching entry.
  always_comb begin
    sel_key = '0;
    sel_val = '0;
    for (int i = 0; i < WAYS; i++) begin
      sel_key = sel_key | ({KEY_BITS{first[i]}} & cell_key[i]);
      sel_val = sel_val | ({VALUE_BITS{first[i]}} & cell_val[i]);
    end
  end

  // The head receives the new or promoted entry, the tail the removed one.
  assign head_key = cmd.insert ? new_key : sel_key;
  assign head_val = cmd.insert ? new_val : sel_val;
  assign tail_key = sel_key;
  assign tail_val = sel_val;

  // The chain of recency cells, most recent first.
  for (genvar g = 0; g < WAYS; g++) begin : g_cell
    logic [KEY_BITS-1:0]   pk, nk;
    logic [VALUE_BITS-1:0] pv, nv;
    logic                  pvld, nvld;

    if (g == 0) begin : g_head
      assign pk   = head_key;
      assign pv   = head_val;
      assign pvld = 1'b1;
    end else begin : g_mid_p
      assign pk   = cell_key[g-1];
      assign pv   = cell_val[g-1];
      assign pvld = cell_vld[g-1];
    end

    if (g == WAYS - 1) begin : g_tail
      assign nk   = tail_key;
      assign nv   = tail_val;
      assign nvld = 1'b0;
    end else begin : g_mid_n
      assign nk   = cell_key[g+1];
      assign nv   = cell_val[g+1];
      assign nvld = cell_vld[g+1];
    end

    lac_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .cmp_en_i   (accept),
      .cmp_key_i  (cmp_key),
      .found_i    (found[g]),
      .found_o    (found[g+1]),
      .first_o    (first[g]),
      .prev_key_i (pk),
      .prev_val_i (pv),
      .prev_vld_i (pvld),
      .next_key_i (nk),
      .next_val_i (nv),
      .next_vld_i (nvld),
      .key_o      (cell_key[g]),
      .val_o      (cell_val[g]),
      .vld_o      (cell_vld[g])
    );
  end

  // Result of the request in its update cycle.
  assign sel_val_ext = 64'(sel_val);
  assign ev_key_ext  = 64'(cell_key[WAYS-1]);

  always_comb begin
    rsp_d               = '0;
    rsp_d.hit           = (cmd.lookup | cmd.remove) & cmd.hit;
    rsp_d.value_res     = (cmd.lookup & cmd.hit) ? sel_val_ext[31:0] : 32'd0;
    rsp_d.evicted_valid = cmd.insert & cell_vld[WAYS-1];
    rsp_d.evicted_key   = (cmd.insert & cell_vld[WAYS-1]) ? ev_key_ext[31:0] : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= cmd.update;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.update) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### sv/lac_checker.sv
// Port-level checks on request and result timing, bound to the cache top level.
module lac_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          rsp_valid_o,
  input lac_pkg::rsp_t rsp_o
);
  import lac_pkg::*;

  // An accepted request holds the request side off for one cycle.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted request");

  // Every accepted request is followed by its result.
  a_rsp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 rsp_valid_o)
    else $error("result missing two cycles after a request");

  // A result only follows an accepted request.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(start && !busy, 2))
    else $error("result without a request");

  // A hit and an eviction never come from the same request.
  a_hit_or_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.hit && rsp_o.evicted_valid))
    else $error("hit and eviction reported together");

  // A miss never carries a value.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.hit) |-> (rsp_o.value_res == 32'd0))
    else $error("value reported on a miss");

endmodule

bind lru_associative_cache_top lac_checker u_lac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);
